[hw/rtl/dtf_pkg.sv]
package dtf_pkg;

  typedef enum logic [1:0] {
    FOP_MUL = 2'd0,
    FOP_DIV = 2'd1,
    FOP_ADD = 2'd2
  } fop_t;

  typedef enum logic [1:0] {
    FREG_V = 2'd0,
    FREG_F = 2'd1,
    FREG_T = 2'd2
  } freg_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch_digit;
    logic       load_digit_v;
    logic [3:0] digit;
    logic       fpu_start;
    fop_t       op;
    logic       big;          // constant 10000 instead of 10
    freg_t      src;
    logic       add_digit;    // second add operand is the digit, else T
    freg_t      dst;
    logic       pack;
    logic       pack_fail;
    logic       pack_special;
    logic       pack_inf;
    logic       pack_neg;
  } dtf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fpu_done;
  } dtf_status_t;

  localparam logic [31:0] FP_INF = 32'h7F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  function automatic logic [31:0] digit_float(input logic [3:0] d);
    logic [31:0] r;
    unique case (d)
      4'd0: r = 32'h0000_0000;
      4'd1: r = 32'h3F80_0000;
      4'd2: r = 32'h4000_0000;
      4'd3: r = 32'h4040_0000;
      4'd4: r = 32'h4080_0000;
      4'd5: r = 32'h40A0_0000;
      4'd6: r = 32'h40C0_0000;
      4'd7: r = 32'h40E0_0000;
      4'd8: r = 32'h4100_0000;
      4'd9: r = 32'h4110_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/dtf_if.sv]
interface dtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface dtf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        failed;
  modport source (output valid, output value_bits, output failed, input ready);
  modport sink (input valid, input value_bits, input failed, output ready);
endinterface

[hw/rtl/dtf_fpu.sv]
// Single-precision unit for nonnegative operands: a*K, a/K (K = 10 or 10000), a+b.
// Every result is rounded to nearest-even, subnormals and overflow included.
module dtf_fpu (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dtf_pkg::fop_t       op,
  input  logic                big,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output logic                done,
  output logic [31:0]         y
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_NORM = 5'b00100,
    F_DEN  = 5'b01000,
    F_RND  = 5'b10000
  } fst_t;

  fst_t               st_r, st_nxt;
  logic [63:0]        m_r, m_nxt;
  logic signed [10:0] eb_r, eb_nxt;     // biased exponent with the MSB at bit 63
  logic               s_r, s_nxt;
  logic [13:0]        rem_r, rem_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               big_r, big_nxt;
  logic               done_r, done_nxt;
  logic [31:0]        y_r, y_nxt;

  logic [23:0]        ma, mb, mbig, msml;
  logic signed [10:0] ea, eb, ebig, esml, diff;
  logic               inf_a, inf_b;
  logic [13:0]        kc, kdiv;
  logic [37:0]        prod;
  logic [26:0]        ext, shifted;
  logic               ast;
  logic [27:0]        asum;
  logic [63:0]        dm;
  logic [13:0]        dr;
  logic [14:0]        tr;
  logic [23:0]        mant;
  logic               rinc;
  logic [24:0]        rsum;
  logic signed [10:0] ef;
  logic [31:0]        packed_y;

  always_comb begin
    inf_a = &a[30:23];
    inf_b = &b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    ea = (a[30:23] == 8'd0) ? -11'sd149 : $signed({3'b000, a[30:23]}) - 11'sd150;
    eb = (b[30:23] == 8'd0) ? -11'sd149 : $signed({3'b000, b[30:23]}) - 11'sd150;
    kc = big ? 14'd10000 : 14'd10;
    prod = {14'd0, ma} * {24'd0, kc};

    if (ea >= eb) begin
      mbig = ma; ebig = ea; msml = mb; esml = eb;
    end else begin
      mbig = mb; ebig = eb; msml = ma; esml = ea;
    end
    diff = ebig - esml;
    ext = {msml, 3'b000};
    if (diff >= 11'sd27) begin
      shifted = 27'd0;
      ast = |msml;
    end else begin
      shifted = ext >> diff[4:0];
      ast = |(ext & ~({27{1'b1}} << diff[4:0]));
    end
    asum = {1'b0, mbig, 3'b000} + {1'b0, shifted};
  end

  // four restoring division steps per cycle
  always_comb begin
    kdiv = big_r ? 14'd10000 : 14'd10;
    dm = m_r;
    dr = rem_r;
    tr = 15'd0;
    for (int i = 0; i < 4; i++) begin
      tr = {dr, dm[63]};
      dm = {dm[62:0], 1'b0};
      if (tr >= {1'b0, kdiv}) begin
        tr = tr - {1'b0, kdiv};
        dm[0] = 1'b1;
      end
      dr = tr[13:0];
    end
  end

  always_comb begin
    mant = m_r[63:40];
    rinc = m_r[39] & ((|m_r[38:0]) | s_r | mant[0]);
    rsum = {1'b0, mant} + {24'd0, rinc};
    ef = eb_r + 11'sd1;
    if (eb_r >= 11'sd255) begin
      packed_y = dtf_pkg::FP_INF;
    end else if (rsum[24]) begin
      packed_y = (ef >= 11'sd255) ? dtf_pkg::FP_INF : {1'b0, ef[7:0], 23'd0};
    end else begin
      packed_y = {1'b0, (rsum[23] ? eb_r[7:0] : 8'd0), rsum[22:0]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    m_nxt = m_r;
    eb_nxt = eb_r;
    s_nxt = s_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    big_nxt = big_r;
    done_nxt = 1'b0;
    y_nxt = y_r;
    unique case (st_r)
      F_IDLE: begin
        if (start) begin
          big_nxt = big;
          if (inf_a || (op == dtf_pkg::FOP_ADD && inf_b)) begin
            y_nxt = dtf_pkg::FP_INF;
            done_nxt = 1'b1;
          end else begin
            unique case (op)
              dtf_pkg::FOP_MUL: begin
                m_nxt = {prod, 26'd0};
                eb_nxt = ea + 11'sd164;
                s_nxt = 1'b0;
                st_nxt = F_NORM;
              end
              dtf_pkg::FOP_ADD: begin
                m_nxt = {asum, 36'd0};
                eb_nxt = ebig + 11'sd151;
                s_nxt = ast;
                st_nxt = F_NORM;
              end
              dtf_pkg::FOP_DIV: begin
                m_nxt = {ma, 40'd0};
                eb_nxt = ea + 11'sd150;
                rem_nxt = 14'd0;
                cnt_nxt = 4'd0;
                st_nxt = F_DIV;
              end
              default: begin
                y_nxt = 32'd0;
                done_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      F_DIV: begin
        m_nxt = dm;
        rem_nxt = dr;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          s_nxt = |dr;
          st_nxt = F_NORM;
        end
      end
      F_NORM: begin
        priority if (m_r == 64'd0) begin
          y_nxt = 32'd0;
          done_nxt = 1'b1;
          st_nxt = F_IDLE;
        end else if (m_r[63:48] == 16'd0) begin
          m_nxt = {m_r[47:0], 16'd0};
          eb_nxt = eb_r - 11'sd16;
        end else if (m_r[63:60] == 4'd0) begin
          m_nxt = {m_r[59:0], 4'd0};
          eb_nxt = eb_r - 11'sd4;
        end else if (!m_r[63]) begin
          m_nxt = {m_r[62:0], 1'b0};
          eb_nxt = eb_r - 11'sd1;
        end else begin
          st_nxt = F_DEN;
        end
      end
      F_DEN: begin
        // shift into the subnormal range one bit a cycle
        priority if (eb_r < -11'sd64) begin
          m_nxt = 64'd0;
          s_nxt = 1'b1;
          eb_nxt = 11'sd1;
          st_nxt = F_RND;
        end else if (eb_r < 11'sd1) begin
          m_nxt = {1'b0, m_r[63:1]};
          s_nxt = s_r | m_r[0];
          eb_nxt = eb_r + 11'sd1;
        end else begin
          st_nxt = F_RND;
        end
      end
      F_RND: begin
        y_nxt = packed_y;
        done_nxt = 1'b1;
        st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    m_r <= m_nxt;
    eb_r <= eb_nxt;
    s_r <= s_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    big_r <= big_nxt;
    y_r <= y_nxt;
  end

  assign done = done_r;
  assign y = y_r;

endmodule

[hw/rtl/dtf_datapath.sv]
module dtf_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtf_pkg::dtf_cmd_t     cmd,
  output dtf_pkg::dtf_status_t  status,
  output logic [31:0]           value_bits,
  output logic                  failed
);

  logic [31:0] v_r, v_nxt;
  logic [31:0] f_r, f_nxt;
  logic [31:0] t_r, t_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic [31:0] value_r, value_nxt;
  logic        failed_r, failed_nxt;
  logic [31:0] op_a, op_b, fpu_y;
  logic        fpu_done;

  always_comb begin
    unique case (cmd.src)
      dtf_pkg::FREG_V: op_a = v_r;
      dtf_pkg::FREG_F: op_a = f_r;
      dtf_pkg::FREG_T: op_a = t_r;
      default:         op_a = v_r;
    endcase
    op_b = cmd.add_digit ? dtf_pkg::digit_float(digit_r) : t_r;
  end

  dtf_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.fpu_start),
    .op    (cmd.op),
    .big   (cmd.big),
    .a     (op_a),
    .b     (op_b),
    .done  (fpu_done),
    .y     (fpu_y)
  );

  always_comb begin
    v_nxt = v_r;
    f_nxt = f_r;
    t_nxt = t_r;
    digit_nxt = cmd.latch_digit ? cmd.digit : digit_r;
    value_nxt = value_r;
    failed_nxt = failed_r;
    if (cmd.load_digit_v) begin
      v_nxt = dtf_pkg::digit_float(cmd.digit);
    end
    if (fpu_done) begin
      unique case (cmd.dst)
        dtf_pkg::FREG_V: v_nxt = fpu_y;
        dtf_pkg::FREG_F: f_nxt = fpu_y;
        dtf_pkg::FREG_T: t_nxt = fpu_y;
        default:         v_nxt = fpu_y;
      endcase
    end
    if (cmd.pack) begin
      failed_nxt = cmd.pack_fail;
      priority if (cmd.pack_fail) begin
        value_nxt = 32'd0;
      end else if (cmd.pack_special) begin
        value_nxt = cmd.pack_inf ? dtf_pkg::FP_INF : dtf_pkg::FP_QNAN;
      end else begin
        value_nxt = {v_r[31] ^ cmd.pack_neg, v_r[30:0]};
      end
      v_nxt = 32'd0;
      f_nxt = 32'd0;
      t_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 32'd0;
      f_r <= 32'd0;
      t_r <= 32'd0;
    end else begin
      v_r <= v_nxt;
      f_r <= f_nxt;
      t_r <= t_nxt;
    end
    digit_r <= digit_nxt;
    value_r <= value_nxt;
    failed_r <= failed_nxt;
  end

  assign status.fpu_done = fpu_done;
  assign value_bits = value_r;
  assign failed = failed_r;

endmodule

[hw/rtl/dtf_ctrl.sv]
module dtf_ctrl #(
  parameter int EXPONENT_LIMIT = 255,
  parameter int FRACTION_DIGIT_LIMIT = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_character,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output dtf_pkg::dtf_cmd_t     cmd,
  input  dtf_pkg::dtf_status_t  status
);

  localparam int EW = $clog2(EXPONENT_LIMIT + 1);
  localparam int FW = $clog2(FRACTION_DIGIT_LIMIT + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  typedef enum logic [6:0] {
    P_START = 7'b0000001,
    P_INT   = 7'b0000010,
    P_FRAC  = 7'b0000100,
    P_EXPS  = 7'b0001000,
    P_EXPP  = 7'b0010000,
    P_EXPN  = 7'b0100000,
    P_SPEC  = 7'b1000000
  } phase_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_INT_MUL  = 11'b00000000010,
    S_INT_ADD  = 11'b00000000100,
    S_FR_ADD   = 11'b00000001000,
    S_FR_MUL   = 11'b00000010000,
    S_CF_FIRST = 11'b00000100000,
    S_CF_LOOP  = 11'b00001000000,
    S_CF_ADD   = 11'b00010000000,
    S_EX4      = 11'b00100000000,
    S_EX1      = 11'b01000000000,
    S_PACK     = 11'b10000000000
  } state_t;

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [1:0] n);
    logic [7:0] r;
    unique case ({w, n})
      4'b00_00: r = 8'h4E;   // NaN
      4'b00_01: r = 8'h61;
      4'b00_10: r = 8'h4E;
      4'b01_00: r = 8'h6E;   // nan
      4'b01_01: r = 8'h61;
      4'b01_10: r = 8'h6E;
      4'b10_00: r = 8'h49;   // Inf
      4'b10_01: r = 8'h6E;
      4'b10_10: r = 8'h66;
      4'b11_00: r = 8'h69;   // inf
      4'b11_01: r = 8'h6E;
      4'b11_10: r = 8'h66;
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  state_t        st_r, st_nxt;
  phase_t        phase_r, phase_nxt;
  logic          neg_r, neg_nxt;
  logic [FW-1:0] fcnt_r, fcnt_nxt;
  logic [EW-1:0] exp_r, exp_nxt;
  logic          expneg_r, expneg_nxt;
  logic [1:0]    wsel_r, wsel_nxt;
  logic [1:0]    wcnt_r, wcnt_nxt;
  logic          err_r, err_nxt;
  logic          fail_r, fail_nxt;
  logic          fin_r, fin_nxt;
  logic          issued_r, issued_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          accept, is_digit, hit;
  logic [3:0]    d;
  logic [EW+3:0] enext;
  logic [EW-1:0] esat;
  logic          done;

  assign in_ready = (st_r == S_IDLE) &&
                    ((in_character != CH_NUL) || !out_valid_r || out_ready);
  assign accept = in_valid && in_ready;
  assign is_digit = (in_character >= CH_ZERO) && (in_character <= CH_NINE);
  assign d = in_character[3:0];
  assign done = status.fpu_done;

  always_comb begin
    enext = (EW + 4)'(exp_r) * (EW + 4)'(10) + (EW + 4)'(d);
    esat = (enext > (EW + 4)'(EXPONENT_LIMIT)) ? EW'(EXPONENT_LIMIT) : enext[EW-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    fcnt_nxt = fcnt_r;
    exp_nxt = exp_r;
    expneg_nxt = expneg_r;
    wsel_nxt = wsel_r;
    wcnt_nxt = wcnt_r;
    err_nxt = err_r;
    fail_nxt = fail_r;
    fin_nxt = fin_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    hit = 1'b0;
    cmd = '0;
    cmd.digit = d;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_character == CH_NUL) begin
            fail_nxt = err_r || !(phase_r == P_INT || phase_r == P_FRAC ||
                                  phase_r == P_EXPP || phase_r == P_EXPN ||
                                  (phase_r == P_SPEC && wcnt_r == 2'd3));
            priority if (fail_nxt) begin
              st_nxt = S_PACK;
            end else if (phase_r == P_FRAC) begin
              fin_nxt = 1'b1;
              st_nxt = S_CF_FIRST;
            end else if (phase_r == P_EXPP || phase_r == P_EXPN) begin
              st_nxt = S_EX4;
            end else begin
              st_nxt = S_PACK;
            end
          end else if (!err_r) begin
            cmd.latch_digit = is_digit;
            unique case (phase_r)
              P_START: begin
                priority if (in_character == CH_MINUS) begin
                  neg_nxt = 1'b1;
                  phase_nxt = P_INT;
                end else if (in_character == CH_PLUS) begin
                  phase_nxt = P_INT;
                end else if (is_digit) begin
                  cmd.load_digit_v = 1'b1;
                  phase_nxt = P_INT;
                end else begin
                  for (int w = 0; w < 4; w++) begin
                    if (!hit && in_character == word_char(2'(w), 2'd0)) begin
                      hit = 1'b1;
                      wsel_nxt = 2'(w);
                    end
                  end
                  if (hit) begin
                    wcnt_nxt = 2'd1;
                    phase_nxt = P_SPEC;
                  end else begin
                    err_nxt = 1'b1;
                  end
                end
              end
              P_INT: begin
                priority if (is_digit) begin
                  st_nxt = S_INT_MUL;
                end else if (in_character == CH_POINT) begin
                  phase_nxt = P_FRAC;
                end else if (in_character == CH_E_LO || in_character == CH_E_UP) begin
                  phase_nxt = P_EXPS;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              P_FRAC: begin
                priority if (is_digit) begin
                  if (fcnt_r < FW'(FRACTION_DIGIT_LIMIT)) begin
                    fcnt_nxt = fcnt_r + FW'(1);
                  end
                  st_nxt = S_FR_ADD;
                end else if (in_character == CH_E_LO || in_character == CH_E_UP) begin
                  fin_nxt = 1'b0;
                  phase_nxt = P_EXPS;
                  st_nxt = S_CF_FIRST;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              P_EXPS: begin
                priority if (is_digit) begin
                  exp_nxt = esat;
                  phase_nxt = P_EXPP;
                end else if (in_character == CH_MINUS) begin
                  expneg_nxt = 1'b1;
                  phase_nxt = P_EXPN;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              P_EXPP, P_EXPN: begin
                if (is_digit) begin
                  exp_nxt = esat;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              P_SPEC: begin
                if (wcnt_r != 2'd3 && in_character == word_char(wsel_r, wcnt_r)) begin
                  wcnt_nxt = wcnt_r + 2'd1;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              default: err_nxt = 1'b1;
            endcase
          end
        end
      end
      S_INT_MUL: begin
        cmd.op = dtf_pkg::FOP_MUL;
        cmd.src = dtf_pkg::FREG_V;
        cmd.dst = dtf_pkg::FREG_V;
        cmd.fpu_start = !issued_r;
        if (done) st_nxt = S_INT_ADD;
      end
      S_INT_ADD: begin
        cmd.op = dtf_pkg::FOP_ADD;
        cmd.src = dtf_pkg::FREG_V;
        cmd.add_digit = 1'b1;
        cmd.dst = dtf_pkg::FREG_V;
        cmd.fpu_start = !issued_r;
        if (done) st_nxt = S_IDLE;
      end
      S_FR_ADD: begin
        cmd.op = dtf_pkg::FOP_ADD;
        cmd.src = dtf_pkg::FREG_F;
        cmd.add_digit = 1'b1;
        cmd.dst = dtf_pkg::FREG_F;
        cmd.fpu_start = !issued_r;
        if (done) st_nxt = S_FR_MUL;
      end
      S_FR_MUL: begin
        cmd.op = dtf_pkg::FOP_MUL;
        cmd.src = dtf_pkg::FREG_F;
        cmd.dst = dtf_pkg::FREG_F;
        cmd.fpu_start = !issued_r;
        if (done) st_nxt = S_IDLE;
      end
      S_CF_FIRST: begin
        cmd.op = dtf_pkg::FOP_DIV;
        cmd.src = dtf_pkg::FREG_F;
        cmd.dst = dtf_pkg::FREG_T;
        cmd.fpu_start = !issued_r;
        if (done) st_nxt = S_CF_LOOP;
      end
      S_CF_LOOP: begin
        // one more divide per counted fraction digit
        cmd.op = dtf_pkg::FOP_DIV;
        cmd.src = dtf_pkg::FREG_T;
        cmd.dst = dtf_pkg::FREG_T;
        if (fcnt_r == '0) begin
          st_nxt = S_CF_ADD;
        end else begin
          cmd.fpu_start = !issued_r;
          if (done) fcnt_nxt = fcnt_r - FW'(1);
        end
      end
      S_CF_ADD: begin
        cmd.op = dtf_pkg::FOP_ADD;
        cmd.src = dtf_pkg::FREG_V;
        cmd.dst = dtf_pkg::FREG_V;
        cmd.fpu_start = !issued_r;
        if (done) st_nxt = fin_r ? S_PACK : S_IDLE;
      end
      S_EX4: begin
        cmd.op = expneg_r ? dtf_pkg::FOP_DIV : dtf_pkg::FOP_MUL;
        cmd.big = 1'b1;
        cmd.src = dtf_pkg::FREG_V;
        cmd.dst = dtf_pkg::FREG_V;
        if (exp_r < EW'(4)) begin
          st_nxt = S_EX1;
        end else begin
          cmd.fpu_start = !issued_r;
          if (done) exp_nxt = exp_r - EW'(4);
        end
      end
      S_EX1: begin
        cmd.op = expneg_r ? dtf_pkg::FOP_DIV : dtf_pkg::FOP_MUL;
        cmd.src = dtf_pkg::FREG_V;
        cmd.dst = dtf_pkg::FREG_V;
        if (exp_r == '0) begin
          st_nxt = S_PACK;
        end else begin
          cmd.fpu_start = !issued_r;
          if (done) exp_nxt = exp_r - EW'(1);
        end
      end
      S_PACK: begin
        cmd.pack = 1'b1;
        cmd.pack_fail = fail_r;
        cmd.pack_special = (phase_r == P_SPEC);
        cmd.pack_inf = wsel_r[1];
        cmd.pack_neg = neg_r;
        out_valid_nxt = 1'b1;
        phase_nxt = P_START;
        neg_nxt = 1'b0;
        fcnt_nxt = '0;
        exp_nxt = '0;
        expneg_nxt = 1'b0;
        wsel_nxt = 2'd0;
        wcnt_nxt = 2'd0;
        err_nxt = 1'b0;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    issued_nxt = issued_r;
    if (cmd.fpu_start) issued_nxt = 1'b1;
    if (done) issued_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      phase_r <= P_START;
      neg_r <= 1'b0;
      fcnt_r <= '0;
      exp_r <= '0;
      expneg_r <= 1'b0;
      wsel_r <= 2'd0;
      wcnt_r <= 2'd0;
      err_r <= 1'b0;
      fail_r <= 1'b0;
      fin_r <= 1'b0;
      issued_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      phase_r <= phase_nxt;
      neg_r <= neg_nxt;
      fcnt_r <= fcnt_nxt;
      exp_r <= exp_nxt;
      expneg_r <= expneg_nxt;
      wsel_r <= wsel_nxt;
      wcnt_r <= wcnt_nxt;
      err_r <= err_nxt;
      fail_r <= fail_nxt;
      fin_r <= fin_nxt;
      issued_r <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/decimal_text_to_float_unit.sv]
// A sign, '.', 'e' or letter starts no FPU operation; an integer digit after the first, or a fraction
// digit, starts two FPU operations, and a leading digit or an exponent digit starts none. A divide uses
// 4-bit restoring division steps; a subnormal result adds denormalizing shifts.
// An 'e' after a fraction, or the NUL, folds the fraction in: (counted digits + 2) operations;
// the NUL then applies exponent/4 + exponent%4 operations, and the result is loaded.
// One string at a time. rst_n is synchronous, active low; it returns the parser to the start.
module decimal_text_to_float_unit #(
  parameter int EXPONENT_LIMIT = 255,
  parameter int FRACTION_DIGIT_LIMIT = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  dtf_in_if.sink     in_chan,
  dtf_out_if.source  out_chan
);

  dtf_pkg::dtf_cmd_t    cmd;
  dtf_pkg::dtf_status_t status;

  dtf_ctrl #(
    .EXPONENT_LIMIT       (EXPONENT_LIMIT),
    .FRACTION_DIGIT_LIMIT (FRACTION_DIGIT_LIMIT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_character (in_chan.character),
    .in_ready     (in_chan.ready),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .cmd          (cmd),
    .status       (status)
  );

  dtf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .value_bits (out_chan.value_bits),
    .failed     (out_chan.failed)
  );

endmodule

[bench/testbench.sv]
module testbench;

  localparam int EXP_CAP = 255;
  localparam int FRAC_CAP = 63;
  localparam int CHAR_TARGET = 1800;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [31:0] F_TEN = 32'h4120_0000;
  localparam logic [31:0] F_TEN_K = 32'h461C_4000;

  typedef enum int {
    P_START, P_INT, P_FRAC, P_EXP_START, P_EXP_POS, P_EXP_NEG, P_WORD
  } parse_phase_t;

  typedef struct {
    logic [31:0] bits;
    bit          failed;
  } conversion_t;

  typedef struct {
    string       text;
    bit          typed;
    logic [31:0] bits;
    bit          failed;
  } directed_row_t;

  logic clk;
  logic rst_n;
  dtf_in_if  chars_if ();
  dtf_out_if result_if ();

  decimal_text_to_float_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (chars_if.sink),
    .out_chan(result_if.source)
  );

  conversion_t pending_results[$];
  int  errors;
  int  cycles;
  int  strings_sent;
  int  chars_sent;
  int  results_checked;
  int  failures_seen;
  bit  no_idle;
  int  stall_left;

  // parser state of the predictor
  parse_phase_t pstate;
  bit           neg;
  logic [31:0]  acc;
  logic [31:0]  frac;
  int           frac_digits;
  int           exp_val;
  bit           exp_neg;
  int           word_idx;
  int           word_len;
  bit           bad;
  logic [7:0]   word_ch[4][3];

  // Arithmetic in double, then one RNE rounding to single: double has more than
  // 2p+2 bits, so add/mul/div results match single-precision rounding exactly.
  function automatic logic [31:0] to_single(input real r);
    logic [63:0] b;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int es;
    int sh;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF) return {b[63], 31'h7F80_0000};
    if (b[62:52] == 11'h000) return {b[63], 31'd0};
    es = int'(b[62:52]) - 1023 + 127;
    sig = {11'd0, 1'b1, b[51:0]};
    sh = (es >= 1) ? 29 : 29 + (1 - es);
    if (sh > 63) sh = 63;
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (es >= 1) begin
      if (kept == (64'd1 << 24)) begin
        kept = kept >> 1;
        es++;
      end
      if (es >= 255) return {b[63], 31'h7F80_0000};
      return {b[63], es[7:0], kept[22:0]};
    end
    return {b[63], kept[30:0]};
  endfunction

  function automatic real to_double(input logic [31:0] s);
    real r;
    if (s[30:23] == 8'hFF) return $bitstoreal({s[31], 11'h7FF, 52'd0});
    if (s[30:23] == 8'h00) begin
      r = real'(s[22:0]) * (2.0 ** -149);
      return s[31] ? -r : r;
    end
    return $bitstoreal({s[31], 11'(int'(s[30:23]) - 127 + 1023), s[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    return to_single(to_double(a) * to_double(b));
  endfunction

  function automatic logic [31:0] f_div(input logic [31:0] a, input logic [31:0] b);
    return to_single(to_double(a) / to_double(b));
  endfunction

  function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
    return to_single(to_double(a) + to_double(b));
  endfunction

  function automatic void clear_parser();
    pstate = P_START;
    neg = 0;
    acc = 32'd0;
    frac = 32'd0;
    frac_digits = 0;
    exp_val = 0;
    exp_neg = 0;
    word_idx = 0;
    word_len = 0;
    bad = 0;
  endfunction

  function automatic void fold_fraction();
    logic [31:0] f;
    f = f_div(frac, F_TEN);
    for (int k = 0; k < frac_digits; k++) f = f_div(f, F_TEN);
    acc = f_add(acc, f);
  endfunction

  function automatic void add_exp_digit(input int d);
    exp_val = exp_val * 10 + d;
    if (exp_val > EXP_CAP) exp_val = EXP_CAP;
  endfunction

  function automatic void scale_by_exponent();
    for (int k = 0; k < exp_val / 4; k++)
      acc = exp_neg ? f_div(acc, F_TEN_K) : f_mul(acc, F_TEN_K);
    for (int k = 0; k < exp_val % 4; k++)
      acc = exp_neg ? f_div(acc, F_TEN) : f_mul(acc, F_TEN);
  endfunction

  function automatic conversion_t close_string();
    conversion_t r;
    bit fl;
    fl = bad;
    r.bits = 32'd0;
    if (!fl) begin
      case (pstate)
        P_INT: ;
        P_FRAC: fold_fraction();
        P_EXP_POS, P_EXP_NEG: scale_by_exponent();
        P_WORD: if (word_len != 3) fl = 1;
        default: fl = 1;
      endcase
    end
    if (!fl) begin
      if (pstate == P_WORD) r.bits = (word_idx < 2) ? dtf_pkg::FP_QNAN : dtf_pkg::FP_INF;
      else r.bits = acc ^ {neg, 31'd0};
    end
    r.failed = fl;
    clear_parser();
    return r;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, output conversion_t r);
    bit is_dig;
    int d;
    is_dig = (c >= "0" && c <= "9");
    d = int'(c) - int'("0");
    if (c == 8'd0) begin
      r = close_string();
      return 1;
    end
    if (bad) return 0;
    case (pstate)
      P_START: begin
        if (c == "-") begin
          neg = 1;
          pstate = P_INT;
        end else if (c == "+") begin
          pstate = P_INT;
        end else if (is_dig) begin
          acc = to_single(real'(d));
          pstate = P_INT;
        end else begin
          bad = 1;
          for (int w = 0; w < 4; w++) begin
            if (bad && c == word_ch[w][0]) begin
              word_idx = w;
              word_len = 1;
              pstate = P_WORD;
              bad = 0;
            end
          end
        end
      end
      P_INT: begin
        if (is_dig) acc = f_add(f_mul(acc, F_TEN), to_single(real'(d)));
        else if (c == ".") pstate = P_FRAC;
        else if (c == "e" || c == "E") pstate = P_EXP_START;
        else bad = 1;
      end
      P_FRAC: begin
        if (is_dig) begin
          frac = f_mul(f_add(frac, to_single(real'(d))), F_TEN);
          if (frac_digits < FRAC_CAP) frac_digits++;
        end else if (c == "e" || c == "E") begin
          fold_fraction();
          pstate = P_EXP_START;
        end else begin
          bad = 1;
        end
      end
      P_EXP_START: begin
        if (is_dig) begin
          add_exp_digit(d);
          pstate = P_EXP_POS;
        end else if (c == "-") begin
          exp_neg = 1;
          pstate = P_EXP_NEG;
        end else begin
          bad = 1;
        end
      end
      P_EXP_POS, P_EXP_NEG: begin
        if (is_dig) add_exp_digit(d);
        else bad = 1;
      end
      P_WORD: begin
        if (word_len < 3 && c == word_ch[word_idx][word_len]) word_len++;
        else bad = 1;
      end
      default: bad = 1;
    endcase
    return 0;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall per transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      result_if.ready = 0;
    end else if (stall_left > 0) begin
      result_if.ready = 0;
      stall_left--;
    end else begin
      result_if.ready = 1;
    end
  end

  always @(posedge clk) begin
    conversion_t exp_r;
    if (rst_n && result_if.valid && result_if.ready) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 17);
      results_checked++;
      if (result_if.failed) failures_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result value_bits=%h failed=%b",
               result_if.value_bits, result_if.failed);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_if.value_bits !== exp_r.bits) begin
          $error("value_bits: expected %h, got %h", exp_r.bits, result_if.value_bits);
          errors++;
        end
        if (result_if.failed !== exp_r.failed) begin
          $error("failed: expected %b, got %b", exp_r.failed, result_if.failed);
          errors++;
        end
      end
    end
  end

  // called at a falling edge; returns at a falling edge after the transaction
  task automatic put_char(input logic [7:0] c, input bit typed, input conversion_t typed_r);
    int gap;
    conversion_t r;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      chars_if.valid = 0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid = 1;
    chars_if.character = c;
    do @(posedge clk); while (!chars_if.ready);
    chars_sent++;
    if (parse_char(c, r)) pending_results.push_back(typed ? typed_r : r);
    @(negedge clk);
  endtask

  task automatic put_string(input string s, input bit typed, input conversion_t typed_r);
    for (int i = 0; i < s.len(); i++) put_char(s[i], 0, typed_r);
    put_char(8'd0, typed, typed_r);
    strings_sent++;
  endtask

  task automatic drain();
    chars_if.valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic string digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string random_number();
    string s;
    int r;
    s = "";
    r = $urandom_range(0, 9);
    if (r < 2) s = "-";
    else if (r < 3) s = "+";
    if ($urandom_range(0, 7) == 0) s = {s, digits($urandom_range(9, 14))};
    else if (s.len() == 0) s = {s, digits($urandom_range(1, 6))};
    else s = {s, digits($urandom_range(0, 6))};
    if ($urandom_range(0, 1)) begin
      s = {s, "."};
      if ($urandom_range(0, 24) == 0) s = {s, digits($urandom_range(60, 70))};
      else s = {s, digits($urandom_range(0, 8))};
    end
    if ($urandom_range(0, 2) == 0) begin
      s = {s, $urandom_range(0, 1) ? "e" : "E"};
      if ($urandom_range(0, 2) == 0) s = {s, "-"};
      if ($urandom_range(0, 19) == 0) s = {s, digits($urandom_range(3, 4))};
      else s = {s, digits($urandom_range(1, 2))};
    end
    return s;
  endfunction

  function automatic string random_string();
    string s;
    int r;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 75) return random_number();
    if (r < 83) begin
      s = {$urandom_range(0, 1) ? "Na" : "na", $urandom_range(0, 1) ? "N" : "n"};
      if ($urandom_range(0, 1)) s = {$urandom_range(0, 1) ? "Inf" : "inf"};
      return s.substr(0, $urandom_range(0, 2));
    end
    s = random_number();
    pos = $urandom_range(0, s.len());
    if (r < 92) begin
      // corrupt one character, or append one, with an arbitrary nonzero byte
      if (pos < s.len()) s[pos] = 8'($urandom_range(1, 255));
      else s = {s, string'(8'($urandom_range(1, 255)))};
    end else begin
      s = "";
      for (int i = 0; i < $urandom_range(1, 6); i++)
        s = {s, string'(8'($urandom_range(1, 255)))};
    end
    return s;
  endfunction

  directed_row_t rows[] = '{
    '{"", 1, 32'h0, 1},
    '{"-", 1, 32'h8000_0000, 0},
    '{"+", 1, 32'h0, 0},
    '{"0", 1, 32'h0, 0},
    '{"9", 1, 32'h4110_0000, 0},
    '{"1.", 1, 32'h3F80_0000, 0},
    '{"+.5", 0, 32'h0, 0},
    '{"-.5", 0, 32'h0, 0},
    '{".5", 1, 32'h0, 1},
    '{"1e-", 1, 32'h3F80_0000, 0},
    '{"1e", 1, 32'h0, 1},
    '{"1e+5", 1, 32'h0, 1},
    '{"NaN", 1, dtf_pkg::FP_QNAN, 0},
    '{"nan", 1, dtf_pkg::FP_QNAN, 0},
    '{"Inf", 1, dtf_pkg::FP_INF, 0},
    '{"inf", 1, dtf_pkg::FP_INF, 0},
    '{"Na", 1, 32'h0, 1},
    '{"-inf", 1, 32'h0, 1},
    '{"NaNx", 1, 32'h0, 1},
    '{"1.5x", 1, 32'h0, 1},
    '{"\377", 1, 32'h0, 1},
    '{"2.5e-3", 0, 32'h0, 0},
    '{"4294967295E9999", 0, 32'h0, 0},
    '{"7e-9999", 0, 32'h0, 0},
    '{"0.123456789012345678901234567890123456789012345678901234567890123456789",
      0, 32'h0, 0}
  };

  initial begin
    conversion_t typed_r;
    word_ch = '{'{"N", "a", "N"}, '{"n", "a", "n"}, '{"I", "n", "f"}, '{"i", "n", "f"}};
    clear_parser();
    errors = 0;
    cycles = 0;
    no_idle = 0;
    stall_left = 0;
    rst_n = 0;
    chars_if.valid = 0;
    chars_if.character = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (rows[i]) begin
      typed_r.bits = rows[i].bits;
      typed_r.failed = rows[i].failed;
      put_string(rows[i].text, rows[i].typed, typed_r);
    end
    // hold off until the block has delivered everything
    drain();

    while (chars_sent < CHAR_TARGET) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 40) == 0) drain();
      put_string(random_string(), 0, typed_r);
    end
    drain();
    repeat (200) @(negedge clk);

    $display("%0d strings, %0d characters, %0d results checked (%0d malformed)",
             strings_sent, chars_sent, results_checked, failures_seen);
    $display("covered signs, fractions, exponents, saturation, special words, bad bytes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
